### hdl/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies property in the same cycle
`define TGB_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);

// condition implies property in the next cycle
`define TGB_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

### hdl/tgb_pkg.sv
// constants and codes for the text glyph blitter
package tgb_pkg;

  localparam int GLYPH_WIDTH_DEF  = 5;
  localparam int GLYPH_HEIGHT_DEF = 8;

  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 11;
  localparam int COLOR_W = 16;
  localparam int CODE_W  = 8;
  localparam int LINE_W  = 3;
  localparam int STORE_AW = CODE_W + LINE_W;
  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int CFG_IDX_W = 3;

  // bit of the background color register that marks clear glyph bits as transparent
  localparam int TRANSPARENT_BIT = 15;

  localparam logic [ADDR_W-1:0]  FB_BASE_RST = 32'hA000_0000;
  localparam logic [SIZE_W-1:0]  WIDE_RST    = 11'd320;
  localparam logic [SIZE_W-1:0]  HIGH_RST    = 11'd240;
  localparam logic [COLOR_W-1:0] FG_RST      = 16'h7FFF;
  localparam logic [COLOR_W-1:0] BG_RST      = 16'h0000;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FB_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FG      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BG      = 3'd4;

  // operation codes of an input word
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_LOAD = 1'b1;

endpackage

### hdl/text_glyph_blitter.sv
// text glyph blitter: glyph store, bit-serial address setup and pixel emitter
// a load word writes one glyph row into the store and gives no output words
// a draw word runs a bit-serial multiply of the pixel row by the screen width, an address
//   step, then GLYPH_WIDTH*GLYPH_HEIGHT pixel words at one pixel word per cycle while out_stall
//   is low; in_stall stays high until the last pixel word is emitted
// an off-grid draw is accepted and dropped, and gives nothing
// rst_n is synchronous: control and config registers reset, the glyph store is not cleared
`include "assert_macros.svh"

module text_glyph_blitter #(
  parameter int GLYPH_WIDTH  = tgb_pkg::GLYPH_WIDTH_DEF,
  parameter int GLYPH_HEIGHT = tgb_pkg::GLYPH_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tgb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic [7:0]                        in_char_code,
  input  logic [7:0]                        in_text_col,
  input  logic [7:0]                        in_text_row,
  input  logic [2:0]                        in_glyph_line,
  input  logic [7:0]                        in_glyph_bits,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [31:0]                       out_pixel_addr,
  output logic [15:0]                       out_pixel_color,
  output logic                              out_write_enable,
  output logic                              out_last
);

  localparam int ADDR_W  = tgb_pkg::ADDR_W;
  localparam int SIZE_W  = tgb_pkg::SIZE_W;
  localparam int COLOR_W = tgb_pkg::COLOR_W;
  localparam int LINE_W  = tgb_pkg::LINE_W;
  localparam int ACC_W   = 2 * SIZE_W + 1;
  localparam int MCAND_W = 2 * SIZE_W;
  localparam int CNT_W   = $clog2(SIZE_W);
  localparam int GRID_W  = SIZE_W + 2;

  localparam logic [LINE_W-1:0] LAST_COL  = LINE_W'(GLYPH_WIDTH - 1);
  localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(GLYPH_HEIGHT - 1);
  localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(SIZE_W - 1);
  localparam logic [ADDR_W-1:0] ROW_BACK  = ADDR_W'(2 * (GLYPH_WIDTH - 1));

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ADDR, S_EMIT} state_t;

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0]  fb_base_r;
  logic [SIZE_W-1:0]  wide_r;
  logic [SIZE_W-1:0]  high_r;
  logic [COLOR_W-1:0] fg_r;
  logic [COLOR_W-1:0] bg_r;

  logic [7:0]         code_r, code_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [MCAND_W-1:0] mcand_r, mcand_nxt;
  logic [SIZE_W-1:0]  mplier_r, mplier_nxt;
  logic [CNT_W-1:0]   step_r, step_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [7:0]         bits_r, bits_nxt;
  logic [LINE_W-1:0]  col_r, col_nxt;
  logic [LINE_W-1:0]  line_r, line_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [COLOR_W-1:0] out_color_r, out_color_nxt;
  logic               out_we_r, out_we_nxt;
  logic               out_last_r, out_last_nxt;

  logic [7:0] glyph_mem [tgb_pkg::STORE_DEPTH];
  logic [7:0] rd_data_r;
  logic       rd_en;
  logic       wr_en;
  logic [tgb_pkg::STORE_AW-1:0] rd_addr;

  logic               in_accept;
  logic               out_free;
  logic               in_grid;
  logic [SIZE_W-1:0]  col_px;
  logic [SIZE_W-1:0]  row_px;
  logic [ADDR_W-1:0]  row_step;
  logic               transparent;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign col_px = SIZE_W'(SIZE_W'(in_text_col) * SIZE_W'(GLYPH_WIDTH));
  assign row_px = SIZE_W'(SIZE_W'(in_text_row) * SIZE_W'(GLYPH_HEIGHT));
  // cell fits when its far edge stays within the screen
  assign in_grid =
    ((GRID_W'(in_text_col) + GRID_W'(1)) * GRID_W'(GLYPH_WIDTH) <= GRID_W'(wide_r)) &&
    ((GRID_W'(in_text_row) + GRID_W'(1)) * GRID_W'(GLYPH_HEIGHT) <= GRID_W'(high_r));

  // jump from the last pixel of a glyph row to the first of the next
  assign row_step    = ADDR_W'({wide_r, 1'b0}) - ROW_BACK;
  assign transparent = bg_r[tgb_pkg::TRANSPARENT_BIT];

  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    step_nxt      = step_r;
    addr_nxt      = addr_r;
    bits_nxt      = bits_r;
    col_nxt       = col_r;
    line_nxt      = line_r;
    out_valid_nxt = out_valid_r;
    out_addr_nxt  = out_addr_r;
    out_color_nxt = out_color_r;
    out_we_nxt    = out_we_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    // prefetch runs one glyph row ahead of the row in bits_r
    rd_addr       = {code_r, line_r + LINE_W'(2)};

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_operation == tgb_pkg::OP_LOAD) begin
            wr_en = 1'b1;
          end else if (in_grid) begin
            code_nxt   = in_char_code;
            acc_nxt    = ACC_W'(col_px);
            mcand_nxt  = MCAND_W'(wide_r);
            mplier_nxt = row_px;
            step_nxt   = '0;
            col_nxt    = '0;
            line_nxt   = '0;
            rd_en      = 1'b1;
            rd_addr    = {in_char_code, LINE_W'(0)};
            state_nxt  = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (step_r == '0) begin
          bits_nxt = rd_data_r;
          rd_en    = 1'b1;
          rd_addr  = {code_r, LINE_W'(1)};
        end
        if (mplier_r[0]) begin
          acc_nxt = acc_r + ACC_W'(mcand_r);
        end
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        step_nxt   = step_r + CNT_W'(1);
        if (step_r == LAST_STEP) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        addr_nxt  = fb_base_r + ADDR_W'({acc_r, 1'b0});
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = addr_r;
          out_color_nxt = bits_r[7] ? fg_r : (transparent ? '0 : bg_r);
          out_we_nxt    = bits_r[7] || !transparent;
          out_last_nxt  = (col_r == LAST_COL) && (line_r == LAST_LINE);
          bits_nxt      = bits_r << 1;
          if (col_r == LAST_COL) begin
            col_nxt  = '0;
            line_nxt = line_r + LINE_W'(1);
            bits_nxt = rd_data_r;
            rd_en    = 1'b1;
            addr_nxt = addr_r + row_step;
            if (line_r == LAST_LINE) begin
              state_nxt = S_IDLE;
            end
          end else begin
            col_nxt  = col_r + LINE_W'(1);
            addr_nxt = addr_r + ADDR_W'(2);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    code_r      <= code_nxt;
    acc_r       <= acc_nxt;
    mcand_r     <= mcand_nxt;
    mplier_r    <= mplier_nxt;
    step_r      <= step_nxt;
    addr_r      <= addr_nxt;
    bits_r      <= bits_nxt;
    col_r       <= col_nxt;
    line_r      <= line_nxt;
    out_addr_r  <= out_addr_nxt;
    out_color_r <= out_color_nxt;
    out_we_r    <= out_we_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_base_r <= tgb_pkg::FB_BASE_RST;
      wide_r    <= tgb_pkg::WIDE_RST;
      high_r    <= tgb_pkg::HIGH_RST;
      fg_r      <= tgb_pkg::FG_RST;
      bg_r      <= tgb_pkg::BG_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tgb_pkg::CFG_FB_BASE: fb_base_r <= cfg_data;
        tgb_pkg::CFG_WIDE:    wide_r    <= cfg_data[SIZE_W-1:0];
        tgb_pkg::CFG_HIGH:    high_r    <= cfg_data[SIZE_W-1:0];
        tgb_pkg::CFG_FG:      fg_r      <= cfg_data[COLOR_W-1:0];
        tgb_pkg::CFG_BG:      bg_r      <= cfg_data[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // glyph store, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      glyph_mem[{in_char_code, in_glyph_line}] <= in_glyph_bits;
    end
    if (rd_en) begin
      rd_data_r <= glyph_mem[rd_addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_addr   = out_addr_r;
  assign out_pixel_color  = out_color_r;
  assign out_write_enable = out_we_r;
  assign out_last         = out_last_r;

  `TGB_ASSERT_NEXT(a_idle_no_pixel, !in_stall && out_valid && !out_stall, !out_valid, "pixel word produced while idle")
  `TGB_ASSERT_NEXT(a_last_to_idle, (state_r == S_EMIT) && out_free && out_last_nxt, (state_r == S_IDLE) && out_valid && out_last, "last pixel did not end the draw")
  `TGB_ASSERT_NOW(a_mul_done, state_r == S_ADDR, mplier_r == '0, "multiplier bits left over")
  `TGB_ASSERT_NOW(a_transparent_zero, out_valid && !out_write_enable, out_pixel_color == '0, "transparent pixel with nonzero color")

endmodule
